FILE: src/mprc_pkg.sv
// mprc_pkg: types, codes and the crc byte step for the modbus power reply checker
// used by mprc_frame and modbus_power_response_check_core; no dependencies
package mprc_pkg;

  localparam int MAX_REGISTERS = 10;

  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;
  localparam logic [5:0]  INDEX_MAX       = 6'd63;
  localparam logic [3:0]  RUN_MAX         = 4'd15;

  localparam logic [7:0] SLAVE_ADDRESS_RESET   = 8'd1;
  localparam logic [3:0] REGISTER_COUNT_RESET  = 4'd10;
  localparam logic [3:0] FAULT_THRESHOLD_RESET = 4'd3;

  localparam logic [1:0] REG_SLAVE_ADDRESS   = 2'd0;
  localparam logic [1:0] REG_REGISTER_COUNT  = 2'd1;
  localparam logic [1:0] REG_FAULT_THRESHOLD = 2'd2;

  localparam logic [1:0] OP_DATA    = 2'd0;
  localparam logic [1:0] OP_LAST    = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  localparam logic [2:0] STATUS_OK       = 3'd0;
  localparam logic [2:0] STATUS_TIMEOUT  = 3'd1;
  localparam logic [2:0] STATUS_LENGTH   = 3'd2;
  localparam logic [2:0] STATUS_ADDRESS  = 3'd3;
  localparam logic [2:0] STATUS_FUNCTION = 3'd4;
  localparam logic [2:0] STATUS_COUNT    = 3'd5;
  localparam logic [2:0] STATUS_CRC      = 3'd6;

  localparam logic [2:0] HERR_ADDR  = 3'b001;
  localparam logic [2:0] HERR_FUNC  = 3'b010;
  localparam logic [2:0] HERR_COUNT = 3'b100;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] power_tenths_watt;
    logic        fault_flag;
    logic        fault_changed;
  } out_item_t;

  typedef struct packed {
    logic [7:0] slave_address;
    logic [3:0] register_count;
    logic [3:0] fault_threshold;
  } cfg_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

FILE: src/mprc_frame.sv
// mprc_frame: per-reply state (byte count, crc, header checks, power word) and fault tracking
// depends on mprc_pkg; result is combinational, registered by the top level
module mprc_frame (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  mprc_pkg::in_item_t  item,
  input  mprc_pkg::cfg_t      cfg,
  output logic                has_result,
  output mprc_pkg::out_item_t result
);
  import mprc_pkg::*;

  logic [5:0]  byte_index;
  logic [15:0] running_crc;
  logic [15:0] crc_prev;
  logic [7:0]  tail_byte;
  logic [2:0]  header_errors;
  logic [31:0] power_word;
  logic [3:0]  error_run;
  logic        fault_state;

  logic [5:0]  regs;
  logic [6:0]  frame_len;
  logic [5:0]  byte_index_next;
  logic [2:0]  header_errors_next;
  logic [31:0] power_word_next;
  logic [15:0] running_crc_next;
  logic [3:0]  error_run_next;
  logic        fault_state_next;
  logic [2:0]  status;
  logic        is_byte;

  always_comb begin
    regs = (6'(cfg.register_count) > 6'(MAX_REGISTERS)) ? 6'(MAX_REGISTERS)
                                                         : 6'(cfg.register_count);
    frame_len = {regs, 1'b0} + 7'd5;
    is_byte = (item.op == OP_DATA) || (item.op == OP_LAST);

    header_errors_next = header_errors;
    if (byte_index == 6'd0 && item.rx_byte != cfg.slave_address)
      header_errors_next = header_errors_next | HERR_ADDR;
    if (byte_index == 6'd1 && item.rx_byte != FUNC_READ_INPUT)
      header_errors_next = header_errors_next | HERR_FUNC;
    if (byte_index == 6'd2 && item.rx_byte != {1'b0, regs, 1'b0})
      header_errors_next = header_errors_next | HERR_COUNT;

    power_word_next = power_word;
    case (byte_index)
      6'd9:    power_word_next[15:8]  = item.rx_byte;
      6'd10:   power_word_next[7:0]   = item.rx_byte;
      6'd11:   power_word_next[31:24] = item.rx_byte;
      6'd12:   power_word_next[23:16] = item.rx_byte;
      default: power_word_next = power_word;
    endcase

    running_crc_next = crc_byte(running_crc, item.rx_byte);
    byte_index_next  = (byte_index < INDEX_MAX) ? byte_index + 6'd1 : byte_index;

    if (item.op == OP_TIMEOUT)
      status = STATUS_TIMEOUT;
    else if ({1'b0, byte_index_next} != frame_len)
      status = STATUS_LENGTH;
    else if ((header_errors_next & HERR_ADDR) != 3'b000)
      status = STATUS_ADDRESS;
    else if ((header_errors_next & HERR_FUNC) != 3'b000)
      status = STATUS_FUNCTION;
    else if ((header_errors_next & HERR_COUNT) != 3'b000)
      status = STATUS_COUNT;
    else if (crc_prev != {item.rx_byte, tail_byte})
      status = STATUS_CRC;
    else
      status = STATUS_OK;

    if (status == STATUS_OK) begin
      error_run_next   = 4'd0;
      fault_state_next = 1'b0;
    end else begin
      error_run_next   = (error_run < RUN_MAX) ? error_run + 4'd1 : error_run;
      fault_state_next = fault_state || (error_run_next >= cfg.fault_threshold);
    end

    has_result               = (item.op == OP_LAST) || (item.op == OP_TIMEOUT);
    result.status            = status;
    result.power_tenths_watt = (status == STATUS_OK) ? power_word_next : 32'd0;
    result.fault_flag        = fault_state_next;
    result.fault_changed     = fault_state_next != fault_state;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index    <= '0;
      running_crc   <= CRC_INIT;
      crc_prev      <= CRC_INIT;
      tail_byte     <= '0;
      header_errors <= '0;
      power_word    <= '0;
      error_run     <= '0;
      fault_state   <= 1'b0;
    end else if (take) begin
      if (has_result) begin
        // end of reply: back to an empty frame
        byte_index    <= '0;
        running_crc   <= CRC_INIT;
        crc_prev      <= CRC_INIT;
        tail_byte     <= '0;
        header_errors <= '0;
        power_word    <= '0;
        error_run     <= error_run_next;
        fault_state   <= fault_state_next;
      end else if (is_byte) begin
        byte_index    <= byte_index_next;
        running_crc   <= running_crc_next;
        crc_prev      <= running_crc;
        tail_byte     <= item.rx_byte;
        header_errors <= header_errors_next;
        power_word    <= power_word_next;
      end
    end
  end

endmodule

FILE: src/modbus_power_response_check_core.sv
// modbus_power_response_check_core: modbus rtu reply checker top level
// depends on mprc_pkg and mprc_frame
// the ending transaction is registered in s1, then its result in the output register
// throughput: one input transaction per cycle, unless out_stall holds back a reply end
// an output register parts the channels, so data bytes are taken while a result waits
// reset (rst, synchronous) empties the pipeline, clears frame and fault state, loads defaults
module modbus_power_response_check_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mprc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mprc_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);
  import mprc_pkg::*;

  cfg_t      cfg;
  logic      s1_valid;
  in_item_t  s1_item;
  logic      s1_fire;
  logic      has_result;
  out_item_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slave_address   <= SLAVE_ADDRESS_RESET;
      cfg.register_count  <= REGISTER_COUNT_RESET;
      cfg.fault_threshold <= FAULT_THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SLAVE_ADDRESS:   cfg.slave_address   <= cfg_data;
        REG_REGISTER_COUNT:  cfg.register_count  <= cfg_data[3:0];
        REG_FAULT_THRESHOLD: cfg.fault_threshold <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign s1_fire  = s1_valid && (!has_result || !out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= in_data;
    end
  end

  mprc_frame u_frame (
    .clk        (clk),
    .rst        (rst),
    .take       (s1_fire),
    .item       (s1_item),
    .cfg        (cfg),
    .has_result (has_result),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && has_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && has_result) begin
      out_data <= result;
    end
  end

endmodule
